@@ design/sff_pkg.sv @@
// ----------------------------------------------------------------------------
// sff_pkg: shared types and constants for the symmetric FIR filter
// Field widths, request opcodes, register indexes, sequencer states and the
// control bundle that the sequencer broadcasts to the tap cells.
// ----------------------------------------------------------------------------
package sff_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_IN_W = 16;
  localparam int CIDX_W    = 6;
  localparam int OUT_W     = 38;
  localparam int TAPCNT_W  = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 7;

  localparam logic [TAPCNT_W-1:0] TAPCNT_RST = 7'd64;

  // request opcodes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_MODE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_SUM
  } sff_state_t;

  typedef struct packed {
    logic coef_we;       // write coefficient into the addressed cell
    logic shift_sample;  // delay line advances by one
    logic load_mirror;   // mirror row takes the reversed coefficient row
    logic rotate;        // mirror row rotates one cell up
    logic mult;          // every cell registers its product
    logic sum_shift;     // product row shifts toward cell 0
  } sff_ctl_t;

endpackage

@@ design/sff_cell.sv @@
// ----------------------------------------------------------------------------
// sff_cell: one filter tap
// Holds one delayed sample, one coefficient, one slot of the mirrored
// coefficient row and one product; passes sample, mirror and product to
// its neighbors.
// ----------------------------------------------------------------------------
module sff_cell #(
  parameter int COEF_BITS = 16,
  parameter int CELL_IDX  = 0,
  parameter int NW        = 7
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sff_pkg::sff_ctl_t                    ctl,
  input  logic [NW-1:0]                        n_taps,
  input  logic [NW-1:0]                        half_taps,
  input  logic                                 sym_mode,
  input  logic [sff_pkg::CIDX_W-1:0]           wr_idx,
  input  logic signed [COEF_BITS-1:0]          wr_coef,
  input  logic signed [sff_pkg::SAMPLE_W-1:0]  smp_in,
  input  logic signed [COEF_BITS-1:0]          mir_src,
  input  logic signed [COEF_BITS-1:0]          mir_in,
  input  logic signed [sff_pkg::OUT_W-1:0]     prod_in,
  output logic signed [sff_pkg::SAMPLE_W-1:0]  smp_out,
  output logic signed [COEF_BITS-1:0]          coef_out,
  output logic signed [COEF_BITS-1:0]          mir_out,
  output logic signed [sff_pkg::OUT_W-1:0]     prod_out
);
  import sff_pkg::*;

  localparam int PW = COEF_BITS + SAMPLE_W;
  localparam int EW = (PW > OUT_W) ? PW : OUT_W;

  logic signed [SAMPLE_W-1:0]  smp_r;
  logic signed [COEF_BITS-1:0] coef_r;
  logic signed [COEF_BITS-1:0] mir_r;
  logic signed [OUT_W-1:0]     prod_r;

  logic                        active;
  logic                        lower;
  logic signed [COEF_BITS-1:0] eff_coef;
  logic signed [PW-1:0]        mul;
  logic signed [EW-1:0]        mul_ext;

  assign active   = CELL_IDX < int'(n_taps);
  assign lower    = CELL_IDX < int'(half_taps);
  // upper half of a folded filter takes the mirrored coefficient
  assign eff_coef = (sym_mode && !lower) ? mir_r : coef_r;
  assign mul      = eff_coef * smp_r;
  assign mul_ext  = EW'(mul);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r <= '0;
    end else if (ctl.shift_sample) begin
      smp_r <= smp_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.coef_we && (int'(wr_idx) == CELL_IDX)) begin
      coef_r <= wr_coef;
    end
    if (ctl.load_mirror) begin
      mir_r <= mir_src;
    end else if (ctl.rotate) begin
      mir_r <= mir_in;
    end
    if (ctl.mult) begin
      prod_r <= active ? mul_ext[OUT_W-1:0] : '0;
    end else if (ctl.sum_shift) begin
      prod_r <= prod_in;
    end
  end

  assign smp_out  = smp_r;
  assign coef_out = coef_r;
  assign mir_out  = mir_r;
  assign prod_out = prod_r;

endmodule

@@ design/sff_ctrl.sv @@
// ----------------------------------------------------------------------------
// sff_ctrl: request sequencer and accumulator
// Writes coefficients; steps one sample request through mirror alignment,
// multiply and drain, sums the drained products, holds the output register.
// ----------------------------------------------------------------------------
module sff_ctrl #(
  parameter int MAX_TAPS = 64,
  parameter int NW       = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_op,
  output logic                              in_stall,
  input  logic [NW-1:0]                     n_taps,
  input  logic signed [sff_pkg::OUT_W-1:0]  prod_head,
  output sff_pkg::sff_ctl_t                 ctl,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [sff_pkg::OUT_W-1:0]  out_filtered
);
  import sff_pkg::*;

  sff_state_t              state_r, state_nxt;
  logic [NW-1:0]           cnt_r, cnt_nxt;
  logic signed [OUT_W-1:0] acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_filtered_r, out_filtered_nxt;
  logic                    in_take;
  logic                    out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    acc_nxt          = acc_r;
    out_filtered_nxt = out_filtered_r;
    out_valid_nxt    = out_valid_r && out_stall;
    ctl              = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_op == OP_COEF) begin
            ctl.coef_we = 1'b1;
          end else begin
            ctl.shift_sample = 1'b1;
            ctl.load_mirror  = 1'b1;
            acc_nxt          = '0;
            cnt_nxt          = n_taps;
            state_nxt        = ST_ROT;
          end
        end
      end
      ST_ROT: begin
        // rotating by n lines mirror slot j up with coefficient n-1-j
        if (cnt_r == '0) begin
          ctl.mult  = 1'b1;
          cnt_nxt   = NW'(MAX_TAPS);
          state_nxt = ST_SUM;
        end else begin
          ctl.rotate = 1'b1;
          cnt_nxt    = cnt_r - 1'b1;
        end
      end
      ST_SUM: begin
        if (cnt_r != '0) begin
          ctl.sum_shift = 1'b1;
          acc_nxt       = acc_r + prod_head;
          cnt_nxt       = cnt_r - 1'b1;
        end else if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_filtered_nxt = acc_r;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r          <= acc_nxt;
    out_filtered_r <= out_filtered_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

endmodule

@@ design/symmetric_fir_filter_unit.sv @@
// ----------------------------------------------------------------------------
// symmetric_fir_filter_unit: direct-form FIR with optional folded taps
// Row of tap cells (sample, coefficient, mirrored coefficient, product)
// driven by one sequencer; signed 16-bit samples, Q1.15 coefficients,
// exact 38-bit result.
//
//   channel | ports                                          | dir
//   --------+------------------------------------------------+-----
//   in      | in_valid/in_stall, in_op, in_sample,           | in
//           | in_coeff_index, in_coeff_value                 |
//   out     | out_valid/out_stall, out_filtered              | out
//   cfg     | cfg_we, cfg_index, cfg_wdata                   | in
//
// Coefficient request: written into the addressed cell when taken; no result.
// Sample request: the sequencer rotates the mirror row (n steps, n = active
// taps), has every cell multiply, then drains the products through the cell row.
// The output register lets the next request in while a result waits.
// Reset (synchronous) zeroes the delay line and sets the registers
// (tap_count 64, symmetric_mode 0); coefficients hold garbage until written.
// ----------------------------------------------------------------------------
module symmetric_fir_filter_unit #(
  parameter int MAX_TAPS  = 64,
  parameter int COEF_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic signed [sff_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [sff_pkg::CIDX_W-1:0]           in_coeff_index,
  input  logic signed [sff_pkg::COEF_IN_W-1:0] in_coeff_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sff_pkg::OUT_W-1:0]     out_filtered,
  input  logic                                 cfg_we,
  input  logic [sff_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sff_pkg::CFG_DAT_W-1:0]        cfg_wdata
);
  import sff_pkg::*;

  localparam int NW = $clog2(MAX_TAPS + 1);
  localparam int CW = (NW > TAPCNT_W) ? NW : TAPCNT_W;
  localparam int XW = (COEF_BITS > COEF_IN_W) ? COEF_BITS : COEF_IN_W;

  logic [TAPCNT_W-1:0]         tap_count_r;
  logic                        sym_mode_r;
  logic [CW-1:0]               tap_ext;
  logic [NW-1:0]               n_taps;
  logic [NW:0]                 n_plus;
  logic [NW-1:0]               half_taps;
  logic signed [XW-1:0]        coef_ext;
  logic signed [COEF_BITS-1:0] wr_coef;
  sff_ctl_t                    ctl;

  logic signed [SAMPLE_W-1:0]  smp_row  [MAX_TAPS];
  logic signed [COEF_BITS-1:0] coef_row [MAX_TAPS];
  logic signed [COEF_BITS-1:0] mir_row  [MAX_TAPS];
  logic signed [OUT_W-1:0]     prod_row [MAX_TAPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAPCNT_RST;
      sym_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAP_COUNT: tap_count_r <= cfg_wdata[TAPCNT_W-1:0];
        REG_SYM_MODE:  sym_mode_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // tap count saturates at the cell count
  assign tap_ext   = CW'(tap_count_r);
  assign n_taps    = (tap_ext > CW'(MAX_TAPS)) ? NW'(MAX_TAPS) : NW'(tap_ext);
  assign n_plus    = (NW + 1)'(n_taps) + 1'b1;
  assign half_taps = NW'(n_plus >> 1);

  // raw field bits; the sign comes from bit COEF_BITS-1 of the stored word
  assign coef_ext = XW'($unsigned(in_coeff_value));
  assign wr_coef  = coef_ext[COEF_BITS-1:0];

  sff_ctrl #(
    .MAX_TAPS (MAX_TAPS),
    .NW       (NW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_op        (in_op),
    .in_stall     (in_stall),
    .n_taps       (n_taps),
    .prod_head    (prod_row[0]),
    .ctl          (ctl),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered)
  );

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] smp_in;
    logic signed [OUT_W-1:0]    prod_in;

    if (i == 0) begin : g_head
      assign smp_in = in_sample;
    end else begin : g_body
      assign smp_in = smp_row[i-1];
    end

    if (i == MAX_TAPS - 1) begin : g_tail
      assign prod_in = '0;
    end else begin : g_mid
      assign prod_in = prod_row[i+1];
    end

    sff_cell #(
      .COEF_BITS (COEF_BITS),
      .CELL_IDX  (i),
      .NW        (NW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .n_taps    (n_taps),
      .half_taps (half_taps),
      .sym_mode  (sym_mode_r),
      .wr_idx    (in_coeff_index),
      .wr_coef   (wr_coef),
      .smp_in    (smp_in),
      .mir_src   (coef_row[MAX_TAPS-1-i]),
      .mir_in    (mir_row[(i + MAX_TAPS - 1) % MAX_TAPS]),
      .prod_in   (prod_in),
      .smp_out   (smp_row[i]),
      .coef_out  (coef_row[i]),
      .mir_out   (mir_row[i]),
      .prod_out  (prod_row[i])
    );
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for symmetric_fir_filter_unit
// Loads the coefficient table, then runs sample and coefficient requests
// under a series of tap counts and fold settings. A built-in tracker mirrors
// the delay line and coefficient table and predicts every filtered result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sff_pkg::*;

  localparam int MAX_TAPS = 64;
  localparam int SETTLE   = 2 * MAX_TAPS + 12;  // worst sample latency plus slack
  localparam int HOLD     = 400;
  localparam int LIMIT    = 600000;
  localparam int PHASES   = 12;
  localparam int PER_PHASE = 31;

  // Mirrors the filter state and keeps the filtered sums still owed by the block.
  class fir_tracker;
    shortint             hist[MAX_TAPS];
    shortint             coef[MAX_TAPS];
    logic [TAPCNT_W-1:0] taps;
    bit                  folded;
    logic [OUT_W-1:0]    pending_sums[$];
    int                  mismatches, strays, checked, samples, coef_writes;

    function new();
      taps   = TAPCNT_RST;
      folded = 1'b0;
      foreach (hist[k]) hist[k] = 0;
      foreach (coef[k]) coef[k] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx == REG_TAP_COUNT) taps = data;
      else if (idx == REG_SYM_MODE) folded = data[0];
    endfunction

    function logic [OUT_W-1:0] filter_sum();
      int     n, m, k;
      longint acc, pre;
      acc = 0;
      n = (taps > MAX_TAPS) ? MAX_TAPS : int'(taps);
      if (folded) begin
        for (k = 0; k < (n + 1) / 2; k++) begin
          m = n - 1 - k;
          pre = hist[k];
          if (m != k) pre += hist[m];  // odd middle tap counted once
          acc += longint'(coef[k]) * pre;
        end
      end else begin
        for (k = 0; k < n; k++) acc += longint'(coef[k]) * longint'(hist[k]);
      end
      return acc[OUT_W-1:0];
    endfunction

    function void take_request(logic op, logic [SAMPLE_W-1:0] smp,
                               logic [CIDX_W-1:0] idx, logic [COEF_IN_W-1:0] val);
      int k;
      if (op == OP_COEF) begin
        coef[idx] = val;
        coef_writes++;
      end else begin
        // whole line shifts regardless of tap count
        for (k = MAX_TAPS - 1; k > 0; k--) hist[k] = hist[k-1];
        hist[0] = smp;
        pending_sums.push_back(filter_sum());
        samples++;
      end
    endfunction

    function void check_filtered(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (pending_sums.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10)
          $display("[%0t] unexpected result %0d", $realtime, $signed(got));
        return;
      end
      want = pending_sums.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches + strays <= 10)
          $display("[%0t] filtered mismatch: expected %0d actual %0d",
                   $realtime, $signed(want), $signed(got));
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_op = OP_FILTER;
  logic signed [SAMPLE_W-1:0]  in_sample = '0;
  logic [CIDX_W-1:0]           in_coeff_index = '0;
  logic signed [COEF_IN_W-1:0] in_coeff_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [OUT_W-1:0]     out_filtered;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DAT_W-1:0]        cfg_wdata = '0;

  fir_tracker sb = new();
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  int  stall_left = 0;
  int  settings = 0;
  int  tap_plan[PHASES]  = '{1, 64, 0, 127, 2, 3, 0, 100, -1, -1, -1, 64};
  int  fold_plan[PHASES] = '{0, 1, 1, 0, 1, 1, 0, 1, -1, -1, -1, 0};

  always #4 clk = ~clk;

  symmetric_fir_filter_unit #(
    .MAX_TAPS (MAX_TAPS),
    .COEF_BITS(16)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_sample     (in_sample),
    .in_coeff_index(in_coeff_index),
    .in_coeff_value(in_coeff_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_filtered  (out_filtered),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // 16-bit word with the corners favored
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_req(input logic op, input logic [SAMPLE_W-1:0] smp,
                          input logic [CIDX_W-1:0] idx, input logic [COEF_IN_W-1:0] val);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_sample      <= smp;
    in_coeff_index <= idx;
    in_coeff_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_request(op, smp, idx, val);
  endtask

  // unused fields carry random content
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    send_req(OP_FILTER, smp, CIDX_W'($urandom), pick_word());
  endtask

  task automatic send_coef(input logic [CIDX_W-1:0] idx, input logic [COEF_IN_W-1:0] val);
    send_req(OP_COEF, pick_word(), idx, val);
  endtask

  // wait for every owed result, then let a trailing coefficient request finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_DAT_W-1:0] tap_val, input bit fold);
    logic [CFG_DAT_W-1:0] fold_word;
    fold_word    = CFG_DAT_W'($urandom);
    fold_word[0] = fold;
    cfg_we    <= 1'b1;
    cfg_index <= REG_TAP_COUNT;
    cfg_wdata <= tap_val;
    @(posedge clk);
    sb.set_reg(REG_TAP_COUNT, tap_val);
    cfg_index <= REG_SYM_MODE;
    cfg_wdata <= fold_word;
    @(posedge clk);
    sb.set_reg(REG_SYM_MODE, fold_word);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // result side: check, then pick the next stall value
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_filtered(out_filtered);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int p, i, tap_val, fold;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every coefficient slot gets written before the first sample
    for (i = 0; i < MAX_TAPS; i++)
      send_coef(CIDX_W'(i),
                (i == 0) ? 16'h8000 : (i == MAX_TAPS - 1) ? 16'h7FFF : pick_word());

    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_coef(CIDX_W'(0), 16'h7FFF);
    send_sample(16'h8000);
    send_coef(CIDX_W'(MAX_TAPS - 1), 16'h8000);
    send_sample(16'h8000);

    for (p = 0; p < PHASES; p++) begin
      settle();
      tap_val = (tap_plan[p] < 0) ? $urandom_range(0, 127) : tap_plan[p];
      fold    = (fold_plan[p] < 0) ? $urandom_range(0, 1) : fold_plan[p];
      write_regs(CFG_DAT_W'(tap_val), 1'(fold));
      if (p == 4) hold_req = 1'b1;
      if (p == PHASES - 1) quiet = 1'b1;
      for (i = 0; i < PER_PHASE; i++) begin
        if ($urandom_range(0, 4) == 0) send_coef(CIDX_W'($urandom), pick_word());
        else send_sample(pick_word());
      end
    end

    settle();
    $display("covered %0d sample requests (%0d results checked) and %0d coefficient writes",
             sb.samples, sb.checked, sb.coef_writes);
    $display("across %0d register settings: tap counts 0, 1, 64, above 64, folded and direct",
             settings);
    if (sb.mismatches + sb.strays + sb.pending_sums.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
